// ----- rtl/mmcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator package
// Field widths, register indexes, command codes, sequencer states and the
// divider status shared by the decimator files.
// ----------------------------------------------------------------------------
package mmcd_pkg;

	localparam int STORE_DEPTH_DEFAULT = 4096;
	localparam int SAMPLE_BITS_DEFAULT = 16;

	localparam int INDEX_W     = 12;
	localparam int COLUMN_W    = 12;
	localparam int VALUE_W     = 16;
	localparam int CFG_W       = 13;
	localparam int CFG_INDEX_W = 8;

	// 2*i*N + W stays below 2^26 for 12-bit i and 13-bit N, W
	localparam int PROD_W     = COLUMN_W + CFG_W;
	localparam int DIVIDEND_W = PROD_W + 1;
	localparam int DIVISOR_W  = CFG_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

	localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = CFG_W'(4096);
	localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = CFG_W'(512);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_END_GO,
		S_END_WAIT,
		S_START_GO,
		S_START_WAIT,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/mmcd_ifs.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator channels
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmcd_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic        [mmcd_pkg::INDEX_W-1:0]  sample_index;
	logic signed [mmcd_pkg::VALUE_W-1:0]  sample_value;
	logic        [mmcd_pkg::COLUMN_W-1:0] column_index;

	modport source (output valid, cmd, sample_index, sample_value, column_index, input ready);
	modport sink (input valid, cmd, sample_index, sample_value, column_index, output ready);
endinterface

interface mmcd_result_if;
	logic                                 valid;
	logic                                 ready;
	logic        [mmcd_pkg::COLUMN_W-1:0] out_column;
	logic signed [mmcd_pkg::VALUE_W-1:0]  max_value;
	logic signed [mmcd_pkg::VALUE_W-1:0]  min_value;

	modport source (output valid, out_column, max_value, min_value, input ready);
	modport sink (input valid, out_column, max_value, min_value, output ready);
endinterface

interface mmcd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mmcd_pkg::CFG_INDEX_W-1:0]    index;
	logic [mmcd_pkg::CFG_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mmcd_divider.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by both
// column boundary computations.
// ----------------------------------------------------------------------------
module mmcd_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [mmcd_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [mmcd_pkg::DIVISOR_W-1:0]      divisor,
	output mmcd_pkg::div_stat_t                 stat,
	output logic [mmcd_pkg::DIVIDEND_W-1:0]     quotient
);

	localparam int DW = mmcd_pkg::DIVIDEND_W;
	localparam int VW = mmcd_pkg::DIVISOR_W;

	logic [VW-1:0]                    rem_q;
	logic [DW-1:0]                    quo_q;
	logic [VW-1:0]                    div_q;
	logic [mmcd_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [VW:0]                      trial;
	logic                             fits;
	logic [VW:0]                      diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mmcd_pkg::DIV_CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mmcd_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- rtl/mmcd_sample_store.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator sample store
// Single write port, single registered read port sample memory.
// ----------------------------------------------------------------------------
module mmcd_sample_store #(
	parameter int DEPTH = mmcd_pkg::STORE_DEPTH_DEFAULT,
	parameter int BITS  = mmcd_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic signed [BITS-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic signed [BITS-1:0]          rdata
);

	logic signed [BITS-1:0] mem_q [DEPTH];
	logic signed [BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mmcd_min_max.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator accumulator
// Running maximum and minimum over the samples read back during a scan.
// ----------------------------------------------------------------------------
module mmcd_min_max #(
	parameter int BITS = mmcd_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   valid,
	input  logic                   first,
	input  logic signed [BITS-1:0] data,
	output logic signed [BITS-1:0] max_val,
	output logic signed [BITS-1:0] min_val
);

	logic signed [BITS-1:0] max_q;
	logic signed [BITS-1:0] min_q;

	always_ff @(posedge clk) begin
		if (valid) begin
			if (first) begin
				max_q <= data;
				min_q <= data;
			end else begin
				if (data > max_q) begin
					max_q <= data;
				end
				if (data < min_q) begin
					min_q <= data;
				end
			end
		end
	end

	assign max_val = max_q;
	assign min_val = min_q;

endmodule

// ----- rtl/min_max_column_decimator.sv -----
// ----------------------------------------------------------------------------
// Min/max column decimator
// Holds display samples and answers column queries with the largest and
// smallest sample of the column's span.
//
//   channel   dir   handshake       word
//   items     in    valid/ready     cmd, sample_index, sample_value, column_index
//   results   out   valid/ready     out_column, max_value, min_value
//   cfg       in    valid/ready     index, data (0 sample_count, 1 column_count)
//
// A query runs the shared serial divider to compute the span's end boundary
// and, for a column other than 0, its start boundary; then the store's one
// read port walks the span.
// Reset clears the sequencer and control flags; the store holds no reset value.
// A finished result waits in the output register while new words are taken;
// a query completes only once that register is free.
// ----------------------------------------------------------------------------
module min_max_column_decimator #(
	parameter int STORE_DEPTH = mmcd_pkg::STORE_DEPTH_DEFAULT,
	parameter int SAMPLE_BITS = mmcd_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	mmcd_item_if.sink       items,
	mmcd_result_if.source   results,
	mmcd_cfg_if.sink        cfg
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = mmcd_pkg::CFG_W;

	mmcd_pkg::state_t                   state_q;
	mmcd_pkg::state_t                   state_d;
	mmcd_pkg::div_stat_t                div_stat;

	logic [CW-1:0]                      sample_count_q;
	logic [CW-1:0]                      column_count_q;
	logic [CW-1:0]                      n_eff;
	logic [CW-1:0]                      w_eff;

	logic [mmcd_pkg::COLUMN_W-1:0]      col_q;
	logic [CW-1:0]                      n_q;
	logic [CW-1:0]                      w_q;
	logic [mmcd_pkg::PROD_W-1:0]        prod_q;
	logic [CW-1:0]                      end_q;
	logic [CW-1:0]                      start_q;
	logic [CW-1:0]                      last_q;
	logic [CW-1:0]                      j_q;
	logic                               issue_s1;
	logic                               first_s1;

	logic                               in_ready;
	logic                               div_start;
	logic                               div_prev;
	logic                               res_load;
	logic                               scan_issue;
	logic                               store_we;

	logic [mmcd_pkg::DIVIDEND_W-1:0]    dividend;
	logic [mmcd_pkg::DIVIDEND_W-1:0]    quotient;
	logic [mmcd_pkg::PROD_W-1:0]        prod_prev;
	logic [CW-1:0]                      n_m1;
	logic [CW-1:0]                      end_clamp;
	logic [CW-1:0]                      start_clamp;

	logic signed [SAMPLE_BITS-1:0]      rdata;
	logic signed [SAMPLE_BITS-1:0]      acc_max;
	logic signed [SAMPLE_BITS-1:0]      acc_min;

	logic                               res_valid_q;
	logic [mmcd_pkg::COLUMN_W-1:0]      res_col_q;
	logic signed [mmcd_pkg::VALUE_W-1:0] res_max_q;
	logic signed [mmcd_pkg::VALUE_W-1:0] res_min_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= mmcd_pkg::SAMPLE_COUNT_RESET;
			column_count_q <= mmcd_pkg::COLUMN_COUNT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				mmcd_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg.data;
				mmcd_pkg::REG_COLUMN_COUNT: column_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sample_count_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(sample_count_q) > 32'(STORE_DEPTH)) begin
			n_eff = CW'(STORE_DEPTH);
		end else begin
			n_eff = sample_count_q;
		end
		w_eff = (column_count_q == '0) ? CW'(1) : column_count_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		div_prev   = 1'b0;
		res_load   = 1'b0;
		scan_issue = 1'b0;
		case (state_q)
			mmcd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (items.valid && items.cmd == mmcd_pkg::CMD_QUERY) begin
					state_d = mmcd_pkg::S_MUL;
				end
			end
			mmcd_pkg::S_MUL: state_d = mmcd_pkg::S_END_GO;
			mmcd_pkg::S_END_GO: begin
				div_start = 1'b1;
				state_d   = mmcd_pkg::S_END_WAIT;
			end
			mmcd_pkg::S_END_WAIT: begin
				if (div_stat.done) begin
					state_d = (col_q == '0) ? mmcd_pkg::S_PREP : mmcd_pkg::S_START_GO;
				end
			end
			mmcd_pkg::S_START_GO: begin
				div_start = 1'b1;
				div_prev  = 1'b1;
				state_d   = mmcd_pkg::S_START_WAIT;
			end
			mmcd_pkg::S_START_WAIT: begin
				if (div_stat.done) begin
					state_d = mmcd_pkg::S_PREP;
				end
			end
			mmcd_pkg::S_PREP: state_d = mmcd_pkg::S_SCAN;
			mmcd_pkg::S_SCAN: begin
				scan_issue = 1'b1;
				if (j_q == last_q) begin
					state_d = mmcd_pkg::S_DRAIN;
				end
			end
			mmcd_pkg::S_DRAIN: state_d = mmcd_pkg::S_OUT;
			mmcd_pkg::S_OUT: begin
				if (!res_valid_q || results.ready) begin
					res_load = 1'b1;
					state_d  = mmcd_pkg::S_IDLE;
				end
			end
			default: state_d = mmcd_pkg::S_IDLE;
		endcase
	end

	assign items.ready = in_ready;

	// boundary arithmetic
	assign prod_prev = prod_q - mmcd_pkg::PROD_W'(n_q);
	assign dividend  = div_prev
		? mmcd_pkg::DIVIDEND_W'({prod_prev, 1'b0}) + mmcd_pkg::DIVIDEND_W'(w_q)
		: mmcd_pkg::DIVIDEND_W'({prod_q, 1'b0}) + mmcd_pkg::DIVIDEND_W'(w_q);

	assign n_m1        = n_q - CW'(1);
	assign end_clamp   = (quotient > mmcd_pkg::DIVIDEND_W'(n_q)) ? n_q : CW'(quotient);
	assign start_clamp = (quotient > mmcd_pkg::DIVIDEND_W'(n_m1)) ? n_m1 : CW'(quotient);

	mmcd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({w_q, 1'b0}),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (in_ready && items.valid) begin
			col_q <= items.column_index;
			n_q   <= n_eff;
			w_q   <= w_eff;
		end
		if (state_q == mmcd_pkg::S_MUL) begin
			prod_q <= mmcd_pkg::PROD_W'(col_q) * mmcd_pkg::PROD_W'(n_q);
		end
		if (state_q == mmcd_pkg::S_END_WAIT && div_stat.done) begin
			end_q <= end_clamp;
			if (col_q == '0) begin
				start_q <= '0;
			end
		end
		if (state_q == mmcd_pkg::S_START_WAIT && div_stat.done) begin
			start_q <= start_clamp;
		end
		if (state_q == mmcd_pkg::S_PREP) begin
			j_q    <= start_q;
			last_q <= (end_q > start_q) ? end_q - CW'(1) : start_q;
		end else if (scan_issue) begin
			j_q <= j_q + CW'(1);
		end
		first_s1 <= (j_q == start_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= scan_issue;
		end
	end

	// sample store and scan
	assign store_we = in_ready && items.valid && items.cmd == mmcd_pkg::CMD_WRITE
		&& (32'(items.sample_index) < 32'(STORE_DEPTH));

	mmcd_sample_store #(
		.DEPTH (STORE_DEPTH),
		.BITS  (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (AW'(items.sample_index)),
		.wdata (SAMPLE_BITS'(items.sample_value)),
		.raddr (AW'(j_q)),
		.rdata (rdata)
	);

	mmcd_min_max #(
		.BITS (SAMPLE_BITS)
	) u_min_max (
		.clk     (clk),
		.valid   (issue_s1),
		.first   (first_s1),
		.data    (rdata),
		.max_val (acc_max),
		.min_val (acc_min)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_col_q <= col_q;
			res_max_q <= mmcd_pkg::VALUE_W'(acc_max);
			res_min_q <= mmcd_pkg::VALUE_W'(acc_min);
		end
	end

	assign results.valid      = res_valid_q;
	assign results.out_column = res_col_q;
	assign results.max_value  = res_max_q;
	assign results.min_value  = res_min_q;

`ifndef NO_ASSERTIONS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> !div_stat.busy)
		else $error("word taken while divider busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == mmcd_pkg::S_END_WAIT
			|| state_q == mmcd_pkg::S_START_WAIT))
		else $error("divider result outside a wait state");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmcd_pkg::S_SCAN) |-> (j_q >= start_q && j_q <= last_q && j_q < n_q))
		else $error("scan address outside span");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || results.ready))
		else $error("result overwritten before taken");
`endif

endmodule
